// ===== rtl/core/xtfe_pkg.sv =====
// ----------------------------------------------------------------------------
// xtfe_pkg: shared types and constants of the tag field extractor
// Phase codes, result kinds, register indexes and the fixed tag texts.
// ----------------------------------------------------------------------------
package xtfe_pkg;

  typedef enum logic [5:0] {
    PH_LINE    = 6'b000001,
    PH_DIR     = 6'b000010,
    PH_SKIP    = 6'b000100,
    PH_COUNT   = 6'b001000,
    PH_ARRTAG  = 6'b010000,
    PH_ARRIVAL = 6'b100000
  } phase_t;

  localparam logic [1:0] KIND_COUNT   = 2'd0;
  localparam logic [1:0] KIND_ARRIVAL = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [1:0] CFG_LINE_ID   = 2'd0;
  localparam logic [1:0] CFG_DIRECTION = 2'd1;

  localparam logic [31:0] LINE_ID_RESET   = 32'h0000_0000;
  localparam logic [7:0]  DIRECTION_RESET = 8'h30;

  localparam logic [7:0] CH_LT = 8'h3C;  // '<'

  // last match position of each pattern, and tag lengths
  localparam logic [3:0] LINE_TAG_LEN = 4'd6;
  localparam logic [3:0] LINE_LAST    = 4'd9;
  localparam logic [3:0] DIR_TAG_LEN  = 4'd7;
  localparam logic [3:0] DIR_LAST     = 4'd7;
  localparam logic [3:0] ARR_TAG_LEN  = 4'd6;
  localparam logic [3:0] ARR_LAST     = 4'd5;
  localparam logic [1:0] COUNT_LAST   = 2'd2;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] match_pos;
    logic [1:0] cap_cnt;
  } ctx_t;

  typedef struct packed {
    logic [1:0] field_kind;
    logic [7:0] data_byte;
    logic       record_done;
  } result_t;

  // "wayId>"
  function automatic logic [7:0] line_tag_char(input logic [2:0] pos);
    case (pos)
      3'd0:    return 8'h77;
      3'd1:    return 8'h61;
      3'd2:    return 8'h79;
      3'd3:    return 8'h49;
      3'd4:    return 8'h64;
      default: return 8'h3E;
    endcase
  endfunction

  // "ordkey>"
  function automatic logic [7:0] dir_tag_char(input logic [2:0] pos);
    case (pos)
      3'd0:    return 8'h6F;
      3'd1:    return 8'h72;
      3'd2:    return 8'h64;
      3'd3:    return 8'h6B;
      3'd4:    return 8'h65;
      3'd5:    return 8'h79;
      default: return 8'h3E;
    endcase
  endfunction

  // "rvlDt>"
  function automatic logic [7:0] arr_tag_char(input logic [2:0] pos);
    case (pos)
      3'd0:    return 8'h72;
      3'd1:    return 8'h76;
      3'd2:    return 8'h6C;
      3'd3:    return 8'h44;
      3'd4:    return 8'h74;
      default: return 8'h3E;
    endcase
  endfunction

endpackage

// ===== rtl/core/xtfe_if.sv =====
// ----------------------------------------------------------------------------
// xtfe_if: request channels of the tag field extractor
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface xtfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xtfe_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] field_kind;
  logic [7:0] data_byte;
  logic       record_done;

  modport source (output valid, output field_kind, output data_byte,
                  output record_done, input ready);
  modport sink   (input valid, input field_kind, input data_byte,
                  input record_done, output ready);
endinterface

// ===== rtl/core/xtfe_step.sv =====
// ----------------------------------------------------------------------------
// xtfe_step: per-byte match and capture logic
// Given the current context and one byte, gives the next context and result.
// ----------------------------------------------------------------------------
module xtfe_step (
  input  xtfe_pkg::ctx_t    ctx,
  input  logic [7:0]        rx_byte,
  input  logic [31:0]       line_id,
  input  logic [7:0]        dir_char,
  output xtfe_pkg::ctx_t    ctx_next,
  output xtfe_pkg::result_t res,
  output logic              res_valid
);

  logic [7:0] expected;
  logic [1:0] id_sel;
  logic       hit;

  assign id_sel = 2'(ctx.match_pos - xtfe_pkg::LINE_TAG_LEN);
  assign hit    = (rx_byte == expected);

  always_comb begin
    expected = '0;
    case (ctx.phase)
      xtfe_pkg::PH_LINE: begin
        if (ctx.match_pos < xtfe_pkg::LINE_TAG_LEN) begin
          expected = xtfe_pkg::line_tag_char(ctx.match_pos[2:0]);
        end else begin
          expected = line_id[(5'd24 - {id_sel, 3'b000}) +: 8];
        end
      end
      xtfe_pkg::PH_DIR: begin
        expected = (ctx.match_pos < xtfe_pkg::DIR_TAG_LEN) ?
                   xtfe_pkg::dir_tag_char(ctx.match_pos[2:0]) : dir_char;
      end
      xtfe_pkg::PH_ARRTAG: begin
        expected = xtfe_pkg::arr_tag_char(
          (ctx.match_pos < xtfe_pkg::ARR_TAG_LEN) ? ctx.match_pos[2:0] : 3'd0);
      end
      default: expected = '0;
    endcase
  end

  always_comb begin
    ctx_next  = ctx;
    res       = '0;
    res_valid = 1'b0;
    case (ctx.phase)
      xtfe_pkg::PH_LINE: begin
        if (!hit) begin
          ctx_next.match_pos = '0;
        end else if (ctx.match_pos >= xtfe_pkg::LINE_LAST) begin
          ctx_next.match_pos = '0;
          ctx_next.phase     = xtfe_pkg::PH_DIR;
        end else begin
          ctx_next.match_pos = ctx.match_pos + 4'd1;
        end
      end
      xtfe_pkg::PH_DIR: begin
        if (!hit) begin
          ctx_next.match_pos = '0;
        end else if (ctx.match_pos >= xtfe_pkg::DIR_LAST) begin
          ctx_next.match_pos = '0;
          ctx_next.phase     = xtfe_pkg::PH_SKIP;
        end else begin
          ctx_next.match_pos = ctx.match_pos + 4'd1;
        end
      end
      xtfe_pkg::PH_SKIP: begin
        ctx_next.cap_cnt = '0;
        ctx_next.phase   = xtfe_pkg::PH_COUNT;
      end
      xtfe_pkg::PH_COUNT: begin
        res_valid      = 1'b1;
        res.field_kind = xtfe_pkg::KIND_COUNT;
        res.data_byte  = rx_byte;
        if (ctx.cap_cnt >= xtfe_pkg::COUNT_LAST) begin
          ctx_next.cap_cnt   = '0;
          ctx_next.match_pos = '0;
          ctx_next.phase     = xtfe_pkg::PH_ARRTAG;
        end else begin
          ctx_next.cap_cnt = ctx.cap_cnt + 2'd1;
        end
      end
      xtfe_pkg::PH_ARRTAG: begin
        if (!hit) begin
          ctx_next.match_pos = '0;
        end else if (ctx.match_pos >= xtfe_pkg::ARR_LAST) begin
          ctx_next.match_pos = '0;
          ctx_next.phase     = xtfe_pkg::PH_ARRIVAL;
        end else begin
          ctx_next.match_pos = ctx.match_pos + 4'd1;
        end
      end
      xtfe_pkg::PH_ARRIVAL: begin
        res_valid = 1'b1;
        if (rx_byte == xtfe_pkg::CH_LT) begin
          res.field_kind     = xtfe_pkg::KIND_END;
          res.record_done    = 1'b1;
          ctx_next.phase     = xtfe_pkg::PH_LINE;
          ctx_next.match_pos = '0;
          ctx_next.cap_cnt   = '0;
        end else begin
          res.field_kind = xtfe_pkg::KIND_ARRIVAL;
          res.data_byte  = rx_byte;
        end
      end
      default: begin
        ctx_next.phase     = xtfe_pkg::PH_LINE;
        ctx_next.match_pos = '0;
        ctx_next.cap_cnt   = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/xml_tag_field_extractor.sv =====
// ----------------------------------------------------------------------------
// xml_tag_field_extractor: streaming tag search and field capture
// Scans response text byte by byte and streams out the selected fields.
// ----------------------------------------------------------------------------
// One received byte is taken per request on rx_chan. The block looks for
// "wayId>" plus the four configured line-id bytes, then "ordkey>" plus the
// configured direction byte, drops one byte, and emits the next three bytes
// as remaining-count bytes (field_kind 0). It then looks for "rvlDt>" and
// emits each later byte as an arrival-time byte (field_kind 1) until a '<',
// which gives an end marker (field_kind 2, data 0, record_done 1) and starts
// the search over. A mismatching byte is consumed and restarts the pattern.
// Throughput is one byte per cycle while res_chan is not stalled; a byte's
// result passes through the input register and then the result register
// before it is presented on res_chan. Bytes that give no result need no room
// in the result register but still wait behind a stalled result. The user
// must write registers via cfg_we/cfg_index/cfg_data only while the block is
// idle; the block does not enforce it. Out-of-range indexes are ignored.
// ----------------------------------------------------------------------------
module xml_tag_field_extractor (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  xtfe_in_if.sink            rx_chan,
  xtfe_out_if.source         res_chan
);

  // configuration registers
  logic [31:0] line_id;
  logic [7:0]  dir_char;

  // input register
  logic        in_v;
  logic [7:0]  in_byte;

  // match context
  xtfe_pkg::ctx_t ctx;
  xtfe_pkg::ctx_t ctx_next;

  // result register
  logic              out_v;
  xtfe_pkg::result_t out_res;

  xtfe_pkg::result_t step_res;
  logic              step_res_v;
  logic              fire;      // input register processed this cycle

  always_ff @(posedge clk) begin
    if (rst) begin
      line_id  <= xtfe_pkg::LINE_ID_RESET;
      dir_char <= xtfe_pkg::DIRECTION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        xtfe_pkg::CFG_LINE_ID:   line_id  <= cfg_data;
        xtfe_pkg::CFG_DIRECTION: dir_char <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // byte is processed when the result register is free or being drained
  assign fire          = in_v && (!out_v || res_chan.ready);
  assign rx_chan.ready = !in_v || fire;

  xtfe_step u_step (
    .ctx       (ctx),
    .rx_byte   (in_byte),
    .line_id   (line_id),
    .dir_char  (dir_char),
    .ctx_next  (ctx_next),
    .res       (step_res),
    .res_valid (step_res_v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (rx_chan.ready) begin
      in_v <= rx_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_chan.ready && rx_chan.valid) begin
      in_byte <= rx_chan.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.phase     <= xtfe_pkg::PH_LINE;
      ctx.match_pos <= '0;
      ctx.cap_cnt   <= '0;
    end else if (fire) begin
      ctx <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (fire) begin
      out_v <= step_res_v;
    end else if (res_chan.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step_res_v) begin
      out_res <= step_res;
    end
  end

  assign res_chan.valid       = out_v;
  assign res_chan.field_kind  = out_res.field_kind;
  assign res_chan.data_byte   = out_res.data_byte;
  assign res_chan.record_done = out_res.record_done;

  // an empty result register never holds off the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_v |-> rx_chan.ready)
    else $error("input stalled with empty result register");

  // end marker always sends the search back to the line-id tag
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && step_res_v && step_res.record_done |=>
      (ctx.phase == xtfe_pkg::PH_LINE) && (ctx.match_pos == 4'd0))
    else $error("end marker did not restart the search");

  // count capture never runs past three bytes
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (ctx.phase == xtfe_pkg::PH_COUNT) |-> (ctx.cap_cnt <= xtfe_pkg::COUNT_LAST))
    else $error("remaining-count capture overran");

  // arrival tag position stays within the tag
  a_arrtag_bound: assert property (@(posedge clk) disable iff (rst)
    (ctx.phase == xtfe_pkg::PH_ARRTAG) |-> (ctx.match_pos <= xtfe_pkg::ARR_LAST))
    else $error("arrival tag position out of range");

  // results only come out of the capture and streaming phases
  a_result_phase: assert property (@(posedge clk) disable iff (rst)
    fire && step_res_v |->
      (ctx.phase == xtfe_pkg::PH_COUNT) || (ctx.phase == xtfe_pkg::PH_ARRIVAL))
    else $error("result produced in a search phase");

endmodule
